[design/pphp_pkg.sv]
// Shared types, codes and constants of the PROXY v2 header parser.
package pphp_pkg;

    localparam int ADDR_BYTES = 36;
    localparam int ADDR_IDX_W = $clog2(ADDR_BYTES);
    localparam int ADDR_VIEW_W = ADDR_BYTES * 8;

    localparam logic [15:0] MAX_LEN_RESET = 16'd256;
    localparam logic [3:0] SIG_LAST = 4'd11;
    localparam logic [3:0] VER_CMD_IDX = 4'd12;
    localparam logic [3:0] FAM_IDX = 4'd13;
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;

    localparam logic [3:0] VERSION_2 = 4'h2;
    localparam logic [3:0] CMD_PROXY = 4'h1;
    localparam logic [3:0] XPORT_STREAM = 4'h1;
    localparam logic [3:0] FAM_INET = 4'h1;
    localparam logic [3:0] FAM_INET6 = 4'h2;
    localparam logic [15:0] INET_MIN_LEN = 16'd12;
    localparam logic [15:0] INET6_MIN_LEN = 16'd36;
    localparam logic [31:0] V4_MAP_PREFIX = 32'h0000_FFFF;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_PAY,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [3:0] {
        ST_MORE         = 4'd0,
        ST_DONE         = 4'd1,
        ST_NOT_CONSUMED = 4'd2,
        ST_SIG          = 4'd3,
        ST_VER          = 4'd4,
        ST_CMD          = 4'd5,
        ST_TRANSPORT    = 4'd6,
        ST_TOOLONG      = 4'd7,
        ST_SHORT        = 4'd8,
        ST_FAMILY       = 4'd9,
        ST_STUCK        = 4'd10
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        is_ipv4;
    } t_result;

    typedef struct packed {
        logic                  en;
        logic [ADDR_IDX_W-1:0] idx;
        logic [7:0]            data;
    } t_addr_wr;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0: b = 8'h0D;
            4'd1: b = 8'h0A;
            4'd2: b = 8'h0D;
            4'd3: b = 8'h0A;
            4'd4: b = 8'h00;
            4'd5: b = 8'h0D;
            4'd6: b = 8'h0A;
            4'd7: b = 8'h51;
            4'd8: b = 8'h55;
            4'd9: b = 8'h49;
            4'd10: b = 8'h54;
            4'd11: b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[design/pphp_addr_buf.sv]
// Storage for the leading payload bytes, with the byte being written merged into the view.
module pphp_addr_buf (
    input  logic                              i_clk,
    input  pphp_pkg::t_addr_wr                i_wr,
    output logic [pphp_pkg::ADDR_VIEW_W-1:0]  o_view
);

    logic [7:0] r_mem [pphp_pkg::ADDR_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
    end

    // Byte zero sits in the top bits so that address fields are plain slices.
    always_comb begin
        for (int i = 0; i < pphp_pkg::ADDR_BYTES; i++) begin
            if (i_wr.en && (i_wr.idx == pphp_pkg::ADDR_IDX_W'(i))) begin
                o_view[pphp_pkg::ADDR_VIEW_W - 1 - 8 * i -: 8] = i_wr.data;
            end else begin
                o_view[pphp_pkg::ADDR_VIEW_W - 1 - 8 * i -: 8] = r_mem[i];
            end
        end
    end

endmodule

[design/pphp_core.sv]
// Parser state and the per-byte decision that produces one result.
module pphp_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_cmd,
    input  logic [7:0]                        i_data_byte,
    input  logic [15:0]                       i_max_len,
    input  logic [pphp_pkg::ADDR_VIEW_W-1:0]  i_view,
    output pphp_pkg::t_addr_wr                o_wr,
    output pphp_pkg::t_result                 o_result
);

    localparam int VW = pphp_pkg::ADDR_VIEW_W;

    pphp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic        r_sig_ok, n_sig_ok;
    logic [7:0]  r_ver_cmd, n_ver_cmd;
    logic [7:0]  r_fam, n_fam;
    logic [15:0] r_len, n_len;

    pphp_pkg::t_result fin;
    logic              fin_ok;
    pphp_pkg::t_result res;
    logic [3:0]        hdr_idx;

    assign hdr_idx = r_count[3:0];

    always_comb begin
        fin = '0;
        fin_ok = 1'b0;
        priority if (r_fam[7:4] == pphp_pkg::FAM_INET) begin
            if (n_len < pphp_pkg::INET_MIN_LEN) begin
                fin.status = pphp_pkg::ST_SHORT;
            end else begin
                fin_ok = 1'b1;
                fin.status = pphp_pkg::ST_DONE;
                fin.src_addr_lo = {pphp_pkg::V4_MAP_PREFIX, i_view[VW - 1 -: 32]};
                fin.dst_addr_lo = {pphp_pkg::V4_MAP_PREFIX, i_view[VW - 33 -: 32]};
                fin.src_port = i_view[VW - 65 -: 16];
                fin.dst_port = i_view[VW - 81 -: 16];
                fin.is_ipv4 = 1'b1;
            end
        end else if (r_fam[7:4] == pphp_pkg::FAM_INET6) begin
            if (n_len < pphp_pkg::INET6_MIN_LEN) begin
                fin.status = pphp_pkg::ST_SHORT;
            end else begin
                fin_ok = 1'b1;
                fin.status = pphp_pkg::ST_DONE;
                fin.src_addr_hi = i_view[VW - 1 -: 64];
                fin.src_addr_lo = i_view[VW - 65 -: 64];
                fin.dst_addr_hi = i_view[VW - 129 -: 64];
                fin.dst_addr_lo = i_view[VW - 193 -: 64];
                fin.src_port = i_view[VW - 257 -: 16];
                fin.dst_port = i_view[VW - 273 -: 16];
            end
        end else begin
            fin.status = pphp_pkg::ST_FAMILY;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sig_ok = r_sig_ok;
        n_ver_cmd = r_ver_cmd;
        n_fam = r_fam;
        n_len = r_len;
        if (i_cmd) begin
            n_phase = pphp_pkg::PH_HDR;
            n_count = '0;
            n_sig_ok = 1'b1;
            n_ver_cmd = '0;
            n_fam = '0;
            n_len = '0;
        end else begin
            unique case (r_phase)
                pphp_pkg::PH_HDR: begin
                    if (hdr_idx <= pphp_pkg::SIG_LAST) begin
                        if (i_data_byte != pphp_pkg::sig_byte(hdr_idx)) begin
                            n_sig_ok = 1'b0;
                        end
                    end else if (hdr_idx == pphp_pkg::VER_CMD_IDX) begin
                        n_ver_cmd = i_data_byte;
                    end else if (hdr_idx == pphp_pkg::FAM_IDX) begin
                        n_fam = i_data_byte;
                    end else if (hdr_idx == pphp_pkg::LEN_HI_IDX) begin
                        n_len = {i_data_byte, r_len[7:0]};
                    end else begin
                        n_len = {r_len[15:8], i_data_byte};
                    end
                    n_count = {12'd0, hdr_idx} + 16'd1;
                    if (hdr_idx == pphp_pkg::LEN_LO_IDX) begin
                        if (!r_sig_ok || r_ver_cmd[7:4] != pphp_pkg::VERSION_2
                                || r_ver_cmd[3:0] != pphp_pkg::CMD_PROXY
                                || r_fam[3:0] != pphp_pkg::XPORT_STREAM
                                || n_len > i_max_len) begin
                            n_phase = pphp_pkg::PH_ERR;
                        end else begin
                            n_count = '0;
                            if (n_len == 16'd0) begin
                                n_phase = fin_ok ? pphp_pkg::PH_DONE : pphp_pkg::PH_ERR;
                            end else begin
                                n_phase = pphp_pkg::PH_PAY;
                            end
                        end
                    end
                end
                pphp_pkg::PH_PAY: begin
                    n_count = r_count + 16'd1;
                    if (n_count >= r_len) begin
                        n_phase = fin_ok ? pphp_pkg::PH_DONE : pphp_pkg::PH_ERR;
                    end
                end
                pphp_pkg::PH_DONE: begin
                end
                pphp_pkg::PH_ERR: begin
                end
            endcase
        end
    end

    always_comb begin
        res = '0;
        if (!i_cmd) begin
            unique case (r_phase)
                pphp_pkg::PH_HDR: begin
                    if (hdr_idx == pphp_pkg::LEN_LO_IDX) begin
                        priority if (!r_sig_ok) begin
                            res.status = pphp_pkg::ST_SIG;
                        end else if (r_ver_cmd[7:4] != pphp_pkg::VERSION_2) begin
                            res.status = pphp_pkg::ST_VER;
                        end else if (r_ver_cmd[3:0] != pphp_pkg::CMD_PROXY) begin
                            res.status = pphp_pkg::ST_CMD;
                        end else if (r_fam[3:0] != pphp_pkg::XPORT_STREAM) begin
                            res.status = pphp_pkg::ST_TRANSPORT;
                        end else if (n_len > i_max_len) begin
                            res.status = pphp_pkg::ST_TOOLONG;
                        end else if (n_len == 16'd0) begin
                            res = fin;
                        end else begin
                            res.status = pphp_pkg::ST_MORE;
                        end
                    end
                end
                pphp_pkg::PH_PAY: begin
                    if (n_count >= r_len) begin
                        res = fin;
                    end
                end
                pphp_pkg::PH_DONE: res.status = pphp_pkg::ST_NOT_CONSUMED;
                pphp_pkg::PH_ERR: res.status = pphp_pkg::ST_STUCK;
            endcase
        end
    end

    assign o_result = res;
    assign o_wr.en = i_step && !i_cmd && (r_phase == pphp_pkg::PH_PAY)
                     && (r_count < 16'(pphp_pkg::ADDR_BYTES));
    assign o_wr.idx = r_count[pphp_pkg::ADDR_IDX_W-1:0];
    assign o_wr.data = i_data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pphp_pkg::PH_HDR;
            r_count <= '0;
            r_sig_ok <= 1'b1;
            r_ver_cmd <= '0;
            r_fam <= '0;
            r_len <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sig_ok <= n_sig_ok;
            r_ver_cmd <= n_ver_cmd;
            r_fam <= n_fam;
            r_len <= n_len;
        end
    end

endmodule

[design/proxy_v2_header_parser_unit.sv]
// Top level of the PROXY v2 header parser: request and result registers around the core.
// The parser takes one request per clock cycle, either a stream byte or a restart command,
// and returns exactly one result per request. A request is held in an input register and
// is decided into the result register as soon as that register is empty or being taken.
// While a finished result waits to be taken, the input register takes at most one more
// request and then holds the request side until the result is taken; full throughput of
// one byte per cycle is kept as long as results are taken. Address fields, ports and
// is_ipv4 are zero unless the status is done. The user must write the payload length
// limit through the configuration channel only while no request is in flight; the block
// itself does not enforce this. The limit resets to 256.
module proxy_v2_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [63:0] o_src_addr_hi,
    output logic [63:0] o_src_addr_lo,
    output logic [63:0] o_dst_addr_hi,
    output logic [63:0] o_dst_addr_lo,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic        o_is_ipv4,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    pphp_pkg::t_result r_out;
    logic [15:0] r_max_len;

    logic              advance;
    pphp_pkg::t_result core_res;
    pphp_pkg::t_addr_wr addr_wr;
    logic [pphp_pkg::ADDR_VIEW_W-1:0] addr_view;

    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    pphp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_cmd       (r_in_cmd),
        .i_data_byte (r_in_byte),
        .i_max_len   (r_max_len),
        .i_view      (addr_view),
        .o_wr        (addr_wr),
        .o_result    (core_res)
    );

    pphp_addr_buf u_addr_buf (
        .i_clk  (i_clk),
        .i_wr   (addr_wr),
        .o_view (addr_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_len <= pphp_pkg::MAX_LEN_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd <= i_cmd;
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_out.status;
    assign o_src_addr_hi = r_out.src_addr_hi;
    assign o_src_addr_lo = r_out.src_addr_lo;
    assign o_dst_addr_hi = r_out.dst_addr_hi;
    assign o_dst_addr_lo = r_out.dst_addr_lo;
    assign o_src_port = r_out.src_port;
    assign o_dst_port = r_out.dst_port;
    assign o_is_ipv4 = r_out.is_ipv4;

endmodule

[design/pphp_checker.sv]
// Port-level assertions for the PROXY v2 header parser and the bind that attaches them.
module pphp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_status,
    input logic [63:0] o_src_addr_hi,
    input logic [63:0] o_src_addr_lo,
    input logic [63:0] o_dst_addr_hi,
    input logic [63:0] o_dst_addr_lo,
    input logic [15:0] o_src_port,
    input logic [15:0] o_dst_port,
    input logic        o_is_ipv4
);

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_src_addr_lo) && $stable(o_dst_addr_lo))
        else $error("result changed while stalled");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request side stalled without a waiting result");

    a_fields_zero_unless_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != pphp_pkg::ST_DONE |->
            o_src_addr_hi == '0 && o_src_addr_lo == '0 && o_dst_addr_hi == '0
            && o_dst_addr_lo == '0 && o_src_port == '0 && o_dst_port == '0
            && !o_is_ipv4)
        else $error("address fields set on a result that is not done");

    a_ipv4_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_ipv4 |->
            o_status == pphp_pkg::ST_DONE && o_src_addr_hi == '0 && o_dst_addr_hi == '0
            && o_src_addr_lo[63:32] == pphp_pkg::V4_MAP_PREFIX
            && o_dst_addr_lo[63:32] == pphp_pkg::V4_MAP_PREFIX)
        else $error("IPv4 result is not a v4-mapped address");

endmodule

bind proxy_v2_header_parser_unit pphp_checker u_pphp_checker (.*);

[bench/tb_proxy_v2_header_parser_unit.sv]
// Self-checking testbench for the PROXY v2 header parser with its own predictor.
`timescale 1ns / 100ps

module tb_proxy_v2_header_parser_unit;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [95:0] SIG_SEQ = 96'h0D0A0D0A000D0A515549540A;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_status;
    logic [63:0] o_src_addr_hi;
    logic [63:0] o_src_addr_lo;
    logic [63:0] o_dst_addr_hi;
    logic [63:0] o_dst_addr_lo;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic        o_is_ipv4;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;

    proxy_v2_header_parser_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_src_addr_hi(o_src_addr_hi),
        .o_src_addr_lo(o_src_addr_lo),
        .o_dst_addr_hi(o_dst_addr_hi),
        .o_dst_addr_lo(o_dst_addr_lo),
        .o_src_port   (o_src_port),
        .o_dst_port   (o_dst_port),
        .o_is_ipv4    (o_is_ipv4),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    pphp_pkg::t_phase conn_phase = pphp_pkg::PH_HDR;
    logic [15:0] conn_count = 16'd0;
    bit          sig_good = 1'b1;
    logic [7:0]  ver_cmd = 8'h00;
    logic [7:0]  fam_xport = 8'h00;
    logic [15:0] pay_len = 16'd0;
    logic [15:0] len_limit = pphp_pkg::MAX_LEN_RESET;
    logic [7:0]  addr_mem [pphp_pkg::ADDR_BYTES];

    pphp_pkg::t_result pending_results [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          no_stall = 1'b0;
    int unsigned ready_hold = 0;

    function automatic void restart_conn();
        conn_phase = pphp_pkg::PH_HDR;
        conn_count = 16'd0;
        sig_good = 1'b1;
        ver_cmd = 8'h00;
        fam_xport = 8'h00;
        pay_len = 16'd0;
    endfunction

    function automatic pphp_pkg::t_result close_payload();
        pphp_pkg::t_result r;
        r = '0;
        if (fam_xport[7:4] == pphp_pkg::FAM_INET && pay_len >= pphp_pkg::INET_MIN_LEN) begin
            r.status = pphp_pkg::ST_DONE;
            r.src_addr_lo = {pphp_pkg::V4_MAP_PREFIX,
                             addr_mem[0], addr_mem[1], addr_mem[2], addr_mem[3]};
            r.dst_addr_lo = {pphp_pkg::V4_MAP_PREFIX,
                             addr_mem[4], addr_mem[5], addr_mem[6], addr_mem[7]};
            r.src_port = {addr_mem[8], addr_mem[9]};
            r.dst_port = {addr_mem[10], addr_mem[11]};
            r.is_ipv4 = 1'b1;
            conn_phase = pphp_pkg::PH_DONE;
        end else if (fam_xport[7:4] == pphp_pkg::FAM_INET6
                     && pay_len >= pphp_pkg::INET6_MIN_LEN) begin
            r.status = pphp_pkg::ST_DONE;
            for (int i = 0; i < 8; i++) begin
                r.src_addr_hi[63 - 8*i -: 8] = addr_mem[i];
                r.src_addr_lo[63 - 8*i -: 8] = addr_mem[8 + i];
                r.dst_addr_hi[63 - 8*i -: 8] = addr_mem[16 + i];
                r.dst_addr_lo[63 - 8*i -: 8] = addr_mem[24 + i];
            end
            r.src_port = {addr_mem[32], addr_mem[33]};
            r.dst_port = {addr_mem[34], addr_mem[35]};
            conn_phase = pphp_pkg::PH_DONE;
        end else if (fam_xport[7:4] == pphp_pkg::FAM_INET
                     || fam_xport[7:4] == pphp_pkg::FAM_INET6) begin
            r.status = pphp_pkg::ST_SHORT;
            conn_phase = pphp_pkg::PH_ERR;
        end else begin
            r.status = pphp_pkg::ST_FAMILY;
            conn_phase = pphp_pkg::PH_ERR;
        end
        return r;
    endfunction

    function automatic pphp_pkg::t_result judge_header();
        pphp_pkg::t_result r;
        r = '0;
        if (!sig_good) r.status = pphp_pkg::ST_SIG;
        else if (ver_cmd[7:4] != pphp_pkg::VERSION_2) r.status = pphp_pkg::ST_VER;
        else if (ver_cmd[3:0] != pphp_pkg::CMD_PROXY) r.status = pphp_pkg::ST_CMD;
        else if (fam_xport[3:0] != pphp_pkg::XPORT_STREAM) r.status = pphp_pkg::ST_TRANSPORT;
        else if (pay_len > len_limit) r.status = pphp_pkg::ST_TOOLONG;
        if (r.status != pphp_pkg::ST_MORE) begin
            conn_phase = pphp_pkg::PH_ERR;
            return r;
        end
        conn_phase = pphp_pkg::PH_PAY;
        conn_count = 16'd0;
        if (pay_len == 16'd0) return close_payload();
        return r;
    endfunction

    function automatic pphp_pkg::t_result parser_step(input logic cmd, input logic [7:0] b);
        pphp_pkg::t_result r;
        logic [3:0] c;
        r = '0;
        if (cmd) begin
            restart_conn();
        end else if (conn_phase == pphp_pkg::PH_DONE) begin
            r.status = pphp_pkg::ST_NOT_CONSUMED;
        end else if (conn_phase == pphp_pkg::PH_ERR) begin
            r.status = pphp_pkg::ST_STUCK;
        end else if (conn_phase == pphp_pkg::PH_HDR) begin
            c = conn_count[3:0];
            if (c <= pphp_pkg::SIG_LAST) begin
                if (b != SIG_SEQ[95 - 8*c -: 8]) sig_good = 1'b0;
            end else if (c == pphp_pkg::VER_CMD_IDX) begin
                ver_cmd = b;
            end else if (c == pphp_pkg::FAM_IDX) begin
                fam_xport = b;
            end else if (c == pphp_pkg::LEN_HI_IDX) begin
                pay_len[15:8] = b;
            end else begin
                pay_len[7:0] = b;
            end
            conn_count = 16'(c) + 16'd1;
            if (conn_count == 16'd16) r = judge_header();
        end else begin
            if (conn_count < pphp_pkg::ADDR_BYTES) addr_mem[conn_count] = b;
            conn_count = conn_count + 16'd1;
            if (conn_count >= pay_len) r = close_payload();
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        if (mismatches <= 60)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        pphp_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("result with no request pending", 64'(o_status), 64'(0));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report("status", 64'(o_status), 64'(want.status));
                if (o_src_addr_hi !== want.src_addr_hi)
                    report("src_addr_hi", o_src_addr_hi, want.src_addr_hi);
                if (o_src_addr_lo !== want.src_addr_lo)
                    report("src_addr_lo", o_src_addr_lo, want.src_addr_lo);
                if (o_dst_addr_hi !== want.dst_addr_hi)
                    report("dst_addr_hi", o_dst_addr_hi, want.dst_addr_hi);
                if (o_dst_addr_lo !== want.dst_addr_lo)
                    report("dst_addr_lo", o_dst_addr_lo, want.dst_addr_lo);
                if (o_src_port !== want.src_port)
                    report("src_port", 64'(o_src_port), 64'(want.src_port));
                if (o_dst_port !== want.dst_port)
                    report("dst_port", 64'(o_dst_port), 64'(want.dst_port));
                if (o_is_ipv4 !== want.is_ipv4)
                    report("is_ipv4", 64'(o_is_ipv4), 64'(want.is_ipv4));
            end
        end
    end

    always @(posedge i_clk) begin : result_side
        int unsigned stall;
        if (o_out_valid && i_out_ready) begin
            stall = no_stall ? 0 : $urandom_range(0, 10);
            ready_hold <= stall;
            i_out_ready <= (stall == 0);
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_out_ready <= (ready_hold == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_req(input logic cmd, input logic [7:0] b);
        int unsigned gap;
        gap = no_stall ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(parser_step(cmd, b));
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        len_limit = value;
    endtask

    task automatic send_header(input logic [7:0] vc, input logic [7:0] fam,
                               input logic [15:0] len, input int bad_at, input int n_bytes);
        logic [7:0] hdr [16];
        for (int i = 0; i < 12; i++) hdr[i] = SIG_SEQ[95 - 8*i -: 8];
        if (bad_at >= 0) hdr[bad_at] = hdr[bad_at] ^ 8'($urandom_range(1, 255));
        hdr[12] = vc;
        hdr[13] = fam;
        hdr[14] = len[15:8];
        hdr[15] = len[7:0];
        for (int i = 0; i < n_bytes; i++) send_req(1'b0, hdr[i]);
    endtask

    task automatic send_payload(input int n, input int fill);
        repeat (n) send_req(1'b0, (fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    task automatic run_conn(input logic [7:0] vc, input logic [7:0] fam, input logic [15:0] len,
                            input int bad_at, input int n_pay, input int fill);
        send_req(1'b1, 8'($urandom));
        send_header(vc, fam, len, bad_at, 16);
        send_payload(n_pay, fill);
    endtask

    task automatic random_connection();
        int unsigned pick;
        logic [7:0] vc;
        logic [7:0] fam;
        logic [15:0] len;
        int bad_at;
        int hdr_n;
        int n_pay;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 20)) send_req($urandom_range(0, 7) == 0, 8'($urandom));
            return;
        end
        vc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h21;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            fam = 8'h11;
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 11))
                                              : 16'($urandom_range(12, 48));
        end else if (pick < 9) begin
            fam = 8'h21;
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 35))
                                              : 16'($urandom_range(36, 64));
        end else begin
            fam = {4'($urandom), 4'h1};
            len = 16'($urandom_range(0, 20));
        end
        if ($urandom_range(0, 9) == 0) fam[3:0] = 4'($urandom);
        if ($urandom_range(0, 19) == 0) len = 16'($urandom);
        bad_at = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 11)) : -1;
        hdr_n = ($urandom_range(0, 19) == 0) ? int'($urandom_range(1, 15)) : 16;
        n_pay = (len > 80) ? 80 : int'(len);
        if ($urandom_range(0, 9) == 0) n_pay = $urandom_range(0, n_pay);
        else n_pay += $urandom_range(0, 3);
        send_req(1'b1, 8'($urandom));
        send_header(vc, fam, len, bad_at, hdr_n);
        if (hdr_n == 16) send_payload(n_pay, -1);
    endtask

    task automatic test_directed_cases();
        send_header(8'h21, 8'h11, 16'd12, -1, 16);
        send_payload(13, -1);
        run_conn(8'h21, 8'h21, 16'd40, -1, 41, 8'hFF);
        run_conn(8'h21, 8'h21, 16'd36, -1, 36, 8'h00);
        run_conn(8'h21, 8'h11, 16'd12, 0, 1, -1);
        run_conn(8'h21, 8'h11, 16'd12, 11, 0, -1);
        run_conn(8'hFF, 8'hFF, 16'hFFFF, 3, 1, -1);
        run_conn(8'h11, 8'h11, 16'd12, -1, 1, -1);
        run_conn(8'h20, 8'h11, 16'd12, -1, 1, -1);
        run_conn(8'h21, 8'h12, 16'd12, -1, 1, -1);
        run_conn(8'h21, 8'h11, 16'd257, -1, 2, -1);
        run_conn(8'h21, 8'h11, 16'd0, -1, 1, -1);
        run_conn(8'h21, 8'h21, 16'd0, -1, 0, -1);
        run_conn(8'h21, 8'h01, 16'd0, -1, 1, -1);
        run_conn(8'h21, 8'h11, 16'd5, -1, 6, -1);
        run_conn(8'h21, 8'h31, 16'd20, -1, 21, -1);
        run_conn(8'h21, 8'h21, 16'd12, -1, 12, -1);
        send_req(1'b1, 8'h00);
        send_header(8'h21, 8'h11, 16'd12, -1, 7);
        send_req(1'b1, 8'hFF);
        run_conn(8'h21, 8'h11, 16'd12, -1, 12, -1);
        run_conn(8'h21, 8'h21, 16'd36, -1, 20, -1);
        run_conn(8'h21, 8'h11, 16'd256, -1, 257, -1);
    endtask

    task automatic test_limit_extremes();
        write_limit(16'd0);
        run_conn(8'h21, 8'h11, 16'd1, -1, 1, -1);
        run_conn(8'h21, 8'h11, 16'd0, -1, 1, -1);
        write_limit(16'hFFFF);
        run_conn(8'h21, 8'h11, 16'hFFFF, -1, 50, -1);
        run_conn(8'h21, 8'h21, 16'hFFFE, -1, 40, -1);
        write_limit(16'hFFFE);
        run_conn(8'h21, 8'h11, 16'hFFFF, -1, 1, -1);
        write_limit(16'd40);
        run_conn(8'h21, 8'h21, 16'd40, -1, 41, -1);
        run_conn(8'h21, 8'h21, 16'd41, -1, 1, -1);
    endtask

    task automatic test_random_traffic(input logic [15:0] limit, input bit steady, input int n);
        int target;
        write_limit(limit);
        no_stall = steady;
        target = items_sent + n;
        while (items_sent < target) random_connection();
        drain();
        no_stall = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < pphp_pkg::ADDR_BYTES; i++) addr_mem[i] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_limit_extremes();
        test_random_traffic(pphp_pkg::MAX_LEN_RESET, 1'b0, 200);
        test_random_traffic(16'd48, 1'b0, 180);
        test_random_traffic(16'hFFFF, 1'b1, 180);
        test_random_traffic(16'd36, 1'b0, 180);
        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[proxy_v2_header_parser_unit.f]
design/pphp_pkg.sv
design/pphp_addr_buf.sv
design/pphp_core.sv
design/proxy_v2_header_parser_unit.sv
design/pphp_checker.sv
bench/tb_proxy_v2_header_parser_unit.sv
